[hdl/bcctig_pkg.sv]
// Shared types and constants for the BCC cell tetrahedron index generator.
// No dependencies; used by the top level and its port checker.
package bcctig_pkg;

   localparam int IDX_W          = 31;  // vertex index width
   localparam int COORD_W        = 10;  // cell coordinate width
   localparam int CORNER_CFG_W   = 11;  // corner count register field width
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 31;
   localparam int NUM_TETS       = 12;
   localparam int TET_CNT_W      = 4;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_CORNERS_X        = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_CORNERS_Y        = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_BODY_CENTER_BASE = CSR_ADDR_W'(2);

   typedef logic [IDX_W-1:0] idx_type;

   // Face triangles, one octal digit per corner code (bit0 +x, bit1 +y, bit2 +z).
   localparam logic [8:0] TRI_EVEN [NUM_TETS] = '{
      9'o013, 9'o032, 9'o457, 9'o476,
      9'o015, 9'o054, 9'o237, 9'o276,
      9'o026, 9'o064, 9'o137, 9'o175
   };

   localparam logic [8:0] TRI_ODD [NUM_TETS] = '{
      9'o012, 9'o132, 9'o456, 9'o576,
      9'o014, 9'o154, 9'o236, 9'o376,
      9'o024, 9'o264, 9'o135, 9'o375
   };

endpackage

[hdl/bcc_cell_tet_index_generator.sv]
// BCC cell tetrahedron index generator, top level.
// Depends on bcctig_pkg.

// One cell coordinate goes in, twelve tetrahedra come out, one per cycle on
// the rsp channel while rsp_ready does not stall it, the twelfth flagged by
// rsp_last_tet. Each tetrahedron is three corner vertex indices (face
// triangle) plus the cell's body-center index on rsp_vertex_d. Cell
// throughput is set by the single result port, fed by the emit stage that
// walks the twelve-entry triangle table. Cells flow through three
// arithmetic stages (register input, multiply, sum) and the emit stage, so
// up to four cells sit inside while an earlier tetrahedron waits in the
// output register; a cell's first tetrahedron passes stages 1 to 4 and then
// the output register. All indices wrap modulo 2^31. Corner count writes
// are clamped to 2..MAX_CORNERS_PER_AXIS. Registers may only be written
// while no cell is in flight.
module bcc_cell_tet_index_generator
   import bcctig_pkg::*;
#(
   parameter int MAX_CORNERS_PER_AXIS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // cell input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_W-1:0]    req_cell_x,
   input  logic [COORD_W-1:0]    req_cell_y,
   input  logic [COORD_W-1:0]    req_cell_z,
   // tetrahedron output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_vertex_a,
   output logic [IDX_W-1:0]      rsp_vertex_b,
   output logic [IDX_W-1:0]      rsp_vertex_c,
   output logic [IDX_W-1:0]      rsp_vertex_d,
   output logic                  rsp_last_tet,
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_CORNERS_PER_AXIS + 1);  // corner count width
   localparam int PW = 2 * CW;                            // cx*cy width
   localparam int ZW = COORD_W + PW;                      // z*cx*cy width
   localparam int YW = COORD_W + CW;                      // y*cx width

   // ---------------------------------------------------------------------
   // Configuration registers and derived plane sizes
   // ---------------------------------------------------------------------
   logic [CW-1:0]    cx_ff, cy_ff;
   logic [IDX_W-1:0] bcb_ff;
   logic [PW-1:0]    cxy_ff;    // corners per z plane
   logic [PW-1:0]    cxy1_ff;   // body centers per z plane
   logic [CW-1:0]    cfg_clamped;
   logic [CORNER_CFG_W-1:0] cfg_raw;

   always_comb begin
      cfg_raw = csr_wdata[CORNER_CFG_W-1:0];
      if (cfg_raw < CORNER_CFG_W'(2)) begin
         cfg_clamped = CW'(2);
      end else if (cfg_raw > CORNER_CFG_W'(MAX_CORNERS_PER_AXIS)) begin
         cfg_clamped = CW'(MAX_CORNERS_PER_AXIS);
      end else begin
         cfg_clamped = CW'(cfg_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= CW'(2);
         cy_ff  <= CW'(2);
         bcb_ff <= IDX_W'(8);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CORNERS_X:        cx_ff  <= cfg_clamped;
            CSR_CORNERS_Y:        cy_ff  <= cfg_clamped;
            CSR_BODY_CENTER_BASE: bcb_ff <= csr_wdata[IDX_W-1:0];
            default: ;  // unknown index, ignored
         endcase
      end
   end

   // follows the registers next cycle; no cell may be in flight, not enforced
   always_ff @(posedge clock) begin
      cxy_ff  <= PW'(cx_ff) * PW'(cy_ff);
      cxy1_ff <= PW'(cx_ff - CW'(1)) * PW'(cy_ff - CW'(1));
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: each stage loads when empty or draining
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_free, s2_free, s3_free, s4_free;
   logic emit, tet_last;
   logic [TET_CNT_W-1:0] tet_cnt_ff;
   logic rsp_valid_ff;

   always_comb begin
      tet_last  = (tet_cnt_ff == TET_CNT_W'(NUM_TETS - 1));
      emit      = s4_valid_ff && (!rsp_valid_ff || rsp_ready);
      s4_free   = !s4_valid_ff || (emit && tet_last);
      s3_free   = !s3_valid_ff || s4_free;
      s2_free   = !s2_valid_ff || s3_free;
      s1_free   = !s1_valid_ff || s2_free;
      req_ready = s1_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         tet_cnt_ff  <= '0;
      end else begin
         if (s1_free) s1_valid_ff <= req_valid;
         if (s2_free) s2_valid_ff <= s1_valid_ff;
         if (s3_free) s3_valid_ff <= s2_valid_ff;
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
            tet_cnt_ff  <= '0;
         end else if (emit) begin
            tet_cnt_ff  <= tet_cnt_ff + TET_CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: register the cell, note its parity
   // ---------------------------------------------------------------------
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic               s1_odd_ff;

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_x_ff   <= req_cell_x;
         s1_y_ff   <= req_cell_y;
         s1_z_ff   <= req_cell_z;
         s1_odd_ff <= req_cell_x[0] ^ req_cell_y[0] ^ req_cell_z[0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: plane and row products
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0]   s2_zterm_ff, s2_z1term_ff;
   logic [YW-1:0]      s2_yterm_ff, s2_y1term_ff;
   logic [COORD_W-1:0] s2_x_ff;
   logic               s2_odd_ff;
   logic [ZW-1:0]      z_cxy_in, z_cxy1_in;
   logic [YW-1:0]      y_cx_in, y_cx1_in;

   always_comb begin
      z_cxy_in  = ZW'(s1_z_ff) * ZW'(cxy_ff);
      z_cxy1_in = ZW'(s1_z_ff) * ZW'(cxy1_ff);
      y_cx_in   = YW'(s1_y_ff) * YW'(cx_ff);
      y_cx1_in  = YW'(s1_y_ff) * YW'(cx_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_zterm_ff  <= IDX_W'(z_cxy_in);
         s2_z1term_ff <= IDX_W'(z_cxy1_in);
         s2_yterm_ff  <= y_cx_in;
         s2_y1term_ff <= y_cx1_in;
         s2_x_ff      <= s1_x_ff;
         s2_odd_ff    <= s1_odd_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: corner-0 index and body-center index
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0] s3_base_ff, s3_bc_ff;
   logic             s3_odd_ff;

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_base_ff <= s2_zterm_ff + IDX_W'(s2_yterm_ff) + IDX_W'(s2_x_ff);
         s3_bc_ff   <= bcb_ff + s2_z1term_ff + IDX_W'(s2_y1term_ff)
                       + IDX_W'(s2_x_ff);
         s3_odd_ff  <= s2_odd_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: all eight corners, held while the cell's tets go out
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0] s4_corner_ff [8];
   logic [IDX_W-1:0] s4_corner_in [8];
   logic [IDX_W-1:0] s4_bc_ff;
   logic             s4_odd_ff;
   logic [IDX_W-1:0] cxw, cxyw;

   always_comb begin
      cxw  = IDX_W'(cx_ff);
      cxyw = IDX_W'(cxy_ff);
      for (int c = 0; c < 8; c++) begin
         s4_corner_in[c] = s3_base_ff
                           + (c[2] ? cxyw : IDX_W'(0))
                           + (c[1] ? cxw  : IDX_W'(0))
                           + IDX_W'(c[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_free) begin
         s4_corner_ff <= s4_corner_in;
         s4_bc_ff     <= s3_bc_ff;
         s4_odd_ff    <= s3_odd_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Emit: table lookup into the output register
   // ---------------------------------------------------------------------
   logic [8:0]       tri_sel;
   logic [IDX_W-1:0] va_ff, vb_ff, vc_ff, vd_ff;
   logic             last_ff;

   assign tri_sel = s4_odd_ff ? TRI_ODD[tet_cnt_ff] : TRI_EVEN[tet_cnt_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         va_ff   <= s4_corner_ff[tri_sel[8:6]];
         vb_ff   <= s4_corner_ff[tri_sel[5:3]];
         vc_ff   <= s4_corner_ff[tri_sel[2:0]];
         vd_ff   <= s4_bc_ff;
         last_ff <= tet_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vertex_a = va_ff;
   assign rsp_vertex_b = vb_ff;
   assign rsp_vertex_c = vc_ff;
   assign rsp_vertex_d = vd_ff;
   assign rsp_last_tet = last_ff;

endmodule

[hdl/bcctig_checker.sv]
// Port-level checker for the BCC cell tetrahedron index generator, with bind.
// Depends on bcctig_pkg and bcc_cell_tet_index_generator.
module bcctig_checker
   import bcctig_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [IDX_W-1:0]      rsp_vertex_a,
   input logic [IDX_W-1:0]      rsp_vertex_b,
   input logic [IDX_W-1:0]      rsp_vertex_c,
   input logic [IDX_W-1:0]      rsp_vertex_d,
   input logic                  rsp_last_tet
);

   logic                 req_fire, rsp_fire;
   logic [TET_CNT_W-1:0] tet_seen_ff;   // tets delivered of current cell
   logic [IDX_W-1:0]     bc_hold_ff;    // body center of current cell
   logic [2:0]           open_ff;       // cells accepted, not fully delivered
   logic                 cell_done;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign cell_done = rsp_fire && rsp_last_tet;

   always_ff @(posedge clock) begin
      if (reset) begin
         tet_seen_ff <= '0;
         open_ff     <= '0;
      end else begin
         if (rsp_fire) begin
            tet_seen_ff <= rsp_last_tet ? '0 : tet_seen_ff + TET_CNT_W'(1);
         end
         open_ff <= open_ff + 3'(req_fire) - 3'(cell_done);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) bc_hold_ff <= rsp_vertex_d;
   end

   // last flag on exactly every twelfth delivered tet
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_last_tet == (tet_seen_ff == TET_CNT_W'(NUM_TETS - 1))))
      else $error("last_tet out of place");

   // all tets of one cell share the body center
   a_body_center_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && tet_seen_ff != '0) |-> (rsp_vertex_d == bc_hold_ff))
      else $error("body center changed within a cell");

   // no result without an accepted cell; bounded number of cells in flight
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> open_ff != '0) and (open_ff <= 3'd5))
      else $error("cells in flight out of bounds");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_vertex_a)
         && $stable(rsp_vertex_b) && $stable(rsp_vertex_c)
         && $stable(rsp_vertex_d) && $stable(rsp_last_tet)))
      else $error("stalled result changed");

   // nothing shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bcc_cell_tet_index_generator bcctig_checker u_bcctig_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for the BCC cell tetrahedron index generator: drives cells and
// register writes, predicts the twelve tetrahedra per cell, and checks every one.
// Depends on bcctig_pkg and bcc_cell_tet_index_generator.
module tb_top;
   import bcctig_pkg::*;

   // Index 3 is not mapped to any register; writes to it must be ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = CSR_ADDR_W'(3);
   localparam int MAX_CORNERS    = 1024;
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
   localparam int TAIL_CYCLES    = 16;     // pipeline is four deep, leave margin

   // Face triangles as three octal corner codes, first vertex in the top digit.
   // Corner code: bit0 +x, bit1 +y, bit2 +z. Even table for even x+y+z.
   localparam bit [8:0] FACES_EVEN [NUM_TETS] = '{
      9'o013, 9'o032, 9'o457, 9'o476, 9'o015, 9'o054,
      9'o237, 9'o276, 9'o026, 9'o064, 9'o137, 9'o175
   };
   localparam bit [8:0] FACES_ODD [NUM_TETS] = '{
      9'o012, 9'o132, 9'o456, 9'o576, 9'o014, 9'o154,
      9'o236, 9'o376, 9'o024, 9'o264, 9'o135, 9'o375
   };

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } cell_coord_type;

   typedef struct packed {
      idx_type a;
      idx_type b;
      idx_type c;
      idx_type d;
      logic    last;
   } tet_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   logic [COORD_W-1:0]    req_cell_x = '0;
   logic [COORD_W-1:0]    req_cell_y = '0;
   logic [COORD_W-1:0]    req_cell_z = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [IDX_W-1:0]      rsp_vertex_a;
   logic [IDX_W-1:0]      rsp_vertex_b;
   logic [IDX_W-1:0]      rsp_vertex_c;
   logic [IDX_W-1:0]      rsp_vertex_d;
   logic                  rsp_last_tet;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   bcc_cell_tet_index_generator u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cell_x   (req_cell_x),
      .req_cell_y   (req_cell_y),
      .req_cell_z   (req_cell_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_vertex_a (rsp_vertex_a),
      .rsp_vertex_b (rsp_vertex_b),
      .rsp_vertex_c (rsp_vertex_c),
      .rsp_vertex_d (rsp_vertex_d),
      .rsp_last_tet (rsp_last_tet),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 8-unit period: high then low.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ----------------------------------------------------------- bench state
   // Shadow copy of the three registers, updated as each write is issued.
   bit [CORNER_CFG_W-1:0] shadow_corners_x = 11'd2;
   bit [CORNER_CFG_W-1:0] shadow_corners_y = 11'd2;
   idx_type               shadow_bc_base   = 31'd8;

   cell_coord_type cells_to_send [$];   // items not yet put on the req channel
   tet_type        pending_tets  [$];   // predicted tetrahedra, oldest first

   int unsigned send_idle_pct  = 0;  // chance per cycle the sender holds off
   int unsigned recv_stall_pct = 0;  // chance per cycle rsp_ready is low
   int unsigned cells_issued   = 0;
   int unsigned cells_taken    = 0;
   int unsigned tets_checked   = 0;
   int unsigned csr_writes     = 0;
   int unsigned idle_settings  = 0;
   int unsigned errors         = 0;
   int unsigned quiet_cycles   = 0;
   logic        req_fire       = 1'b0;   // req handshake seen at the last rising edge
   cell_coord_type next_coord;
   tet_type        got_tet;
   tet_type        want_tet;

   // ------------------------------------------------------------- predictor
   function automatic bit [CORNER_CFG_W-1:0] clamp_corner_count(
      input bit [CSR_DATA_W-1:0] v);
      bit [CORNER_CFG_W-1:0] n;
      n = v[CORNER_CFG_W-1:0];
      if (n < 2) return 11'd2;
      if (n > MAX_CORNERS) return CORNER_CFG_W'(MAX_CORNERS);
      return n;
   endfunction

   // Work out the twelve tetrahedra of one cell under the current shadow
   // registers and queue them. Everything is done in 64 bits, then cut to 31.
   function automatic void predict_cell_tets(input cell_coord_type coord);
      longint unsigned cx, cy, px, py, pz;
      idx_type         corner_idx [8];
      idx_type         body_center;
      bit [8:0]        face;
      tet_type         t_out;
      cx = shadow_corners_x;
      cy = shadow_corners_y;
      body_center = idx_type'(longint'(shadow_bc_base)
                    + longint'(coord.z) * (cx - 1) * (cy - 1)
                    + longint'(coord.y) * (cx - 1) + longint'(coord.x));
      for (int k = 0; k < 8; k++) begin
         px = longint'(coord.x) + (k & 1);
         py = longint'(coord.y) + ((k >> 1) & 1);
         pz = longint'(coord.z) + ((k >> 2) & 1);
         corner_idx[k] = idx_type'(pz * cx * cy + py * cx + px);
      end
      for (int t = 0; t < NUM_TETS; t++) begin
         face = (coord.x[0] ^ coord.y[0] ^ coord.z[0]) ? FACES_ODD[t]
                                                       : FACES_EVEN[t];
         t_out.a    = corner_idx[face[8:6]];
         t_out.b    = corner_idx[face[5:3]];
         t_out.c    = corner_idx[face[2:0]];
         t_out.d    = body_center;
         t_out.last = (t == NUM_TETS - 1);
         pending_tets.insert(pending_tets.size(), t_out);
      end
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // --------------------------------------------------------------- monitor
   // Samples both channels at the rising edge. A req handshake snapshots the
   // prediction right away, so a register write can never leak into it.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_cell_tets('{x: req_cell_x, y: req_cell_y, z: req_cell_z});
            cells_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got_tet = '{a: rsp_vertex_a, b: rsp_vertex_b, c: rsp_vertex_c,
                        d: rsp_vertex_d, last: rsp_last_tet};
            if (pending_tets.size() == 0) begin
               errors++;
               $display("%0t: unexpected tetrahedron, expected none, %s",
                        $time, "got");
               $display("   %0d %0d %0d %0d last=%0b",
                        got_tet.a, got_tet.b, got_tet.c, got_tet.d, got_tet.last);
            end else begin
               want_tet = pending_tets.pop_front();
               check_field("vertex_a", want_tet.a, got_tet.a);
               check_field("vertex_b", want_tet.b, got_tet.b);
               check_field("vertex_c", want_tet.c, got_tet.c);
               check_field("vertex_d", want_tet.d, got_tet.d);
               check_field("last_tet", want_tet.last, got_tet.last);
               tets_checked++;
            end
         end
      end
      // Watchdog: any handshake on either side counts as progress.
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- driver
   // Runs on the falling edge. valid holds with a fixed payload until the
   // handshake seen at the previous rising edge; only then may it drop or
   // move to the next item. rsp_ready is rerolled every cycle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (cells_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_coord = cells_to_send.pop_front();
               cells_issued++;
               req_valid  <= 1'b1;
               req_cell_x <= next_coord.x;
               req_cell_y <= next_coord.y;
               req_cell_z <= next_coord.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------- sequence
   task automatic send_cell(input int x, input int y, input int z);
      cell_coord_type coord;
      coord = '{x: COORD_W'(x), y: COORD_W'(y), z: COORD_W'(z)};
      cells_to_send.insert(cells_to_send.size(), coord);
   endtask

   // Register write, one cycle of write enable. The shadow copy follows the
   // block's rules: corner counts are cut to 11 bits and clamped, unmapped
   // indexes change nothing.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CORNERS_X:        shadow_corners_x = clamp_corner_count(data);
         CSR_CORNERS_Y:        shadow_corners_y = clamp_corner_count(data);
         CSR_BODY_CENTER_BASE: shadow_bc_base   = data;
         default:              ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sender holds off until every queued item is taken and every predicted
   // tetrahedron has come back, then a few more cycles for the pipeline.
   task automatic wait_drained();
      while (cells_to_send.size() != 0 || cells_taken != cells_issued
             || pending_tets.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Corner count write data: mostly in range, some at the ends, and some
   // raw 31-bit words so the clamp and the ignored upper bits get hit.
   function automatic logic [CSR_DATA_W-1:0] random_corner_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return CSR_DATA_W'(2);
      if (pick < 20) return CSR_DATA_W'(MAX_CORNERS);
      if (pick < 35) return CSR_DATA_W'($urandom);
      if (pick < 60) return CSR_DATA_W'($urandom_range(2, 16));
      return CSR_DATA_W'($urandom_range(2, MAX_CORNERS));
   endfunction

   // Most cells lie inside the lattice; the rest use any 10-bit coordinate.
   task automatic queue_random_cells(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85)
            send_cell($urandom_range(shadow_corners_x - 2),
                      $urandom_range(shadow_corners_y - 2),
                      $urandom_range(1022));
         else
            send_cell($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end
   endtask

   initial begin
      int unsigned idle_mode [4][2];
      idle_mode = '{'{0, 0}, '{68, 0}, '{0, 68}, '{10, 10}};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset registers, both parities, coordinates past the lattice.
      send_cell(0, 0, 0);
      send_cell(1, 0, 0);
      send_cell(1023, 1023, 1023);
      send_cell(1023, 1023, 1022);
      wait_drained();

      // Largest lattice with the top base: body-center sums wrap past 2^31.
      write_csr(CSR_CORNERS_X, CSR_DATA_W'(MAX_CORNERS));
      write_csr(CSR_CORNERS_Y, CSR_DATA_W'(MAX_CORNERS));
      write_csr(CSR_BODY_CENTER_BASE, 31'h7FFF_FFFF);
      send_cell(0, 0, 0);
      send_cell(1022, 1022, 1022);
      send_cell(1021, 1022, 1022);
      send_cell(1023, 1023, 1023);
      send_cell(512, 341, 682);
      send_cell(511, 682, 341);
      wait_drained();

      // Corner counts below the minimum clamp up to 2.
      write_csr(CSR_CORNERS_X, CSR_DATA_W'(0));
      write_csr(CSR_CORNERS_Y, CSR_DATA_W'(1));
      write_csr(CSR_BODY_CENTER_BASE, CSR_DATA_W'(0));
      send_cell(0, 0, 5);
      send_cell(0, 0, 6);
      wait_drained();

      // Above the maximum clamps down to 1024.
      write_csr(CSR_CORNERS_X, CSR_DATA_W'(1025));
      write_csr(CSR_CORNERS_Y, CSR_DATA_W'(2047));
      write_csr(CSR_BODY_CENTER_BASE, 31'h4000_0000);
      send_cell(1022, 1022, 1023);
      send_cell(3, 5, 7);
      wait_drained();

      // Upper write bits are dropped before the clamp; unmapped index ignored.
      write_csr(CSR_CORNERS_X, 31'h7FFF_F803);
      write_csr(CSR_CORNERS_Y, 31'h0000_0800);
      write_csr(CSR_UNMAPPED, 31'h0123_4567);
      send_cell(1, 0, 9);
      send_cell(0, 0, 9);
      send_cell(2, 1, 1000);
      wait_drained();

      // Random part: two passes over the four idle settings, fresh registers
      // each time, and a full drain halfway through every setting.
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_CORNERS_X, random_corner_word());
         write_csr(CSR_CORNERS_Y, random_corner_word());
         write_csr(CSR_BODY_CENTER_BASE,
                   ($urandom_range(4) == 0) ? 31'h7FFF_FFFF : CSR_DATA_W'($urandom));
         if ($urandom_range(3) == 0)
            write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom));
         send_idle_pct  = idle_mode[ph % 4][0];
         recv_stall_pct = idle_mode[ph % 4][1];
         idle_settings++;
         queue_random_cells(22);
         wait_drained();
         queue_random_cells(22);
         wait_drained();
      end

      $display("Sent %0d cells under %0d random idle settings, checked %0d tetrahedra,",
               cells_taken, idle_settings, tets_checked);
      $display("with %0d register writes covering clamped, wrapped and unmapped cases.",
               csr_writes);
      if (errors == 0 && pending_tets.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d tetrahedra still expected", errors, pending_tets.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
